// ===== rtl/core/compass_heading_averager_macros.svh =====
// Assertion macros shared by the compass heading averager RTL.
`ifndef COMPASS_HEADING_AVERAGER_MACROS_SVH
`define COMPASS_HEADING_AVERAGER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cha_pkg.sv =====
// Shared constants, types and the arctangent table of the heading averager.
package cha_pkg;

   localparam int SAMPLES      = 10;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int TARGET       = (SAMPLES < 1) ? 1 : SAMPLES;
   localparam int STEPS        = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   localparam int RAW_W   = 12;
   localparam int DEC_W   = 16;
   localparam int DEG_W   = 9;
   localparam int NUM_W   = 15;
   localparam int SPAN_W  = 13;
   localparam int ONE_Q   = 14;
   localparam int QSAT_W  = 16;
   localparam int COMP_W  = 17;
   localparam int CORD_W  = 20;
   localparam int ANG_W   = 17;
   localparam int STEP_W  = $clog2(ATAN_LEN + 1);
   localparam int CNT_W   = $clog2(TARGET + 1);
   localparam int SUM_W   = 19 + $clog2(TARGET);

   localparam int DIV_N_W   = 32;
   localparam int DIV_D_W   = 22;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   localparam int TURN      = 65536;
   localparam int HALF_TURN = TURN / 2;
   localparam int TOTAL     = TARGET * TURN;
   localparam int DEG_TURN  = 360;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_X_LOW  = 3'd0,
      REG_X_HIGH = 3'd1,
      REG_Y_LOW  = 3'd2,
      REG_Y_HIGH = 3'd3,
      REG_DECL   = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_CORDIC,
      ST_WRAP,
      ST_SCALE,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                    done;
      logic signed [ANG_W-1:0] angle;
   } cordic_rsp_type;

   // atan(2^-i) in binary angle units, rounded to nearest
   function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [ANG_W-1:0] v;
      unique case (idx)
         STEP_W'(0):  v = ANG_W'(8192);
         STEP_W'(1):  v = ANG_W'(4836);
         STEP_W'(2):  v = ANG_W'(2555);
         STEP_W'(3):  v = ANG_W'(1297);
         STEP_W'(4):  v = ANG_W'(651);
         STEP_W'(5):  v = ANG_W'(326);
         STEP_W'(6):  v = ANG_W'(163);
         STEP_W'(7):  v = ANG_W'(81);
         STEP_W'(8):  v = ANG_W'(41);
         STEP_W'(9):  v = ANG_W'(20);
         STEP_W'(10): v = ANG_W'(10);
         STEP_W'(11): v = ANG_W'(5);
         STEP_W'(12): v = ANG_W'(3);
         STEP_W'(13): v = ANG_W'(1);
         STEP_W'(14): v = ANG_W'(1);
         default:     v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/cha_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module cha_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cha_pkg::DIV_N_W-1:0] dividend,
   input  logic [cha_pkg::DIV_D_W-1:0] divisor,
   output logic                        done,
   output logic [cha_pkg::DIV_N_W-1:0] quotient
);

   logic [cha_pkg::DIV_N_W-1:0]   quo_ff, quo_in;
   logic [cha_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [cha_pkg::DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [cha_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [cha_pkg::DIV_D_W:0]     trial;

   assign trial = {rem_ff, quo_ff[cha_pkg::DIV_N_W-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = cha_pkg::DIV_D_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[cha_pkg::DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[cha_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[cha_pkg::DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cha_pkg::DIV_CNT_W'(cha_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/cha_cordic.sv =====
// Iterative vectoring CORDIC: atan2 in binary angle units, one step per cycle.
module cha_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [cha_pkg::COMP_W-1:0] x_in,
   input  logic signed [cha_pkg::COMP_W-1:0] y_in,
   output cha_pkg::cordic_rsp_type           rsp
);

   logic signed [cha_pkg::CORD_W-1:0] x_ff, x_in_v, y_ff, y_in_v;
   logic signed [cha_pkg::CORD_W-1:0] x_sh, y_sh;
   logic signed [cha_pkg::ANG_W:0]    z_ff, z_in, step_ang;
   logic [cha_pkg::STEP_W-1:0]        step_ff, step_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   assign x_sh     = x_ff >>> step_ff;
   assign y_sh     = y_ff >>> step_ff;
   assign step_ang = $signed({1'b0, cha_pkg::atan_entry(step_ff)});

   always_comb begin
      x_in_v  = x_ff;
      y_in_v  = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = '0;
         x_in_v  = cha_pkg::CORD_W'(x_in);
         y_in_v  = cha_pkg::CORD_W'(y_in);
         z_in    = '0;
         if (x_in == '0 && y_in == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            // left half plane: turn by half a turn first
            if (x_in < 0) begin
               z_in   = (y_in >= 0) ? (cha_pkg::ANG_W + 1)'(cha_pkg::HALF_TURN)
                                    : -(cha_pkg::ANG_W + 1)'(cha_pkg::HALF_TURN);
               x_in_v = -cha_pkg::CORD_W'(x_in);
               y_in_v = -cha_pkg::CORD_W'(y_in);
            end
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in_v = x_ff + y_sh;
            y_in_v = y_ff - x_sh;
            z_in   = z_ff + step_ang;
         end else begin
            x_in_v = x_ff - y_sh;
            y_in_v = y_ff + x_sh;
            z_in   = z_ff - step_ang;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == cha_pkg::STEP_W'(cha_pkg::STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff <= x_in_v;
      y_ff <= y_in_v;
      z_ff <= z_in;
   end

   // clamp into one half turn either way
   always_comb begin
      rsp.done = done_ff;
      if (z_ff < -(cha_pkg::ANG_W + 1)'(cha_pkg::HALF_TURN)) begin
         rsp.angle = -cha_pkg::ANG_W'(cha_pkg::HALF_TURN);
      end else if (z_ff > (cha_pkg::ANG_W + 1)'(cha_pkg::HALF_TURN)) begin
         rsp.angle = cha_pkg::ANG_W'(cha_pkg::HALF_TURN);
      end else begin
         rsp.angle = z_ff[cha_pkg::ANG_W-1:0];
      end
   end

endmodule

// ===== rtl/core/compass_heading_averager.sv =====
// Top level of the averaged magnetometer heading block.
//
// Input channel req_*: one raw X/Y sample per beat (valid/ready). Each sample
// is scaled per axis by the calibration span with a 32-step serial divider,
// turned into an angle by a 16-step CORDIC and added, with the declination,
// into a running sum. The divider and then the CORDIC work one step per cycle
// each; the CORDIC takes no steps when both components are zero. The block
// takes no new sample until it is through with the last one.
// Result channel rsp_*: after every SAMPLES samples one beat carries the mean
// heading in whole degrees, 0..359. The sample that completes a set then passes
// through wrap, scale, a second 32-step divide and output load before the
// result shows.
// The result sits in an output register; the next sample is taken while it
// waits. If the receiver still holds off when the next result is ready, the
// block stalls on that result and takes no new sample until it moves.
// Configuration port csr_*: single-cycle register writes; the user must write
// only while idle, which the block does not enforce. Reset clears the sum and
// count, restores the calibration defaults and drops any pending result.
`include "compass_heading_averager_macros.svh"

module compass_heading_averager (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [cha_pkg::RAW_W-1:0] req_x_raw,
   input  logic signed [cha_pkg::RAW_W-1:0] req_y_raw,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cha_pkg::DEG_W-1:0]        rsp_heading_deg,
   input  logic                             csr_wr_en,
   input  logic [cha_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cha_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   cha_pkg::state_type state_ff, state_in;

   logic signed [cha_pkg::RAW_W-1:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic signed [cha_pkg::DEC_W-1:0] decl_ff;

   logic signed [cha_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [cha_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [cha_pkg::SUM_W-1:0]        wrap_ff, wrap_in;
   logic                             x_neg_ff, x_neg_in, x_ok_ff, x_ok_in;
   logic                             y_neg_ff, y_neg_in, y_ok_ff, y_ok_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [cha_pkg::DEG_W-1:0]        rsp_deg_ff, rsp_deg_in;

   logic req_accept, div_x_start, div_y_start, cordic_start, out_load;

   logic signed [cha_pkg::NUM_W-1:0]  x_num, y_num;
   logic signed [cha_pkg::SPAN_W-1:0] x_span, y_span;
   logic [cha_pkg::NUM_W-1:0]         x_mag, y_mag;
   logic [cha_pkg::DIV_N_W-1:0]       div_x_dividend, div_y_dividend, scaled;
   logic [cha_pkg::DIV_D_W-1:0]       div_x_divisor, div_y_divisor;
   logic [cha_pkg::DIV_N_W-1:0]       div_x_quo, div_y_quo;
   logic                              div_x_done, div_y_done;
   logic [cha_pkg::QSAT_W-1:0]        x_qsat, y_qsat;
   logic signed [cha_pkg::COMP_W-1:0] x_comp, y_comp;
   cha_pkg::cordic_rsp_type           cordic_rsp;
   logic [cha_pkg::DEG_W-1:0]         deg_val;

   assign req_accept = req_valid && req_ready;

   // numerator 2*(raw-low) - span == 2*raw - low - high
   assign x_num  = (cha_pkg::NUM_W'(req_x_raw) <<< 1) - cha_pkg::NUM_W'(x_low_ff)
                 - cha_pkg::NUM_W'(x_high_ff);
   assign y_num  = (cha_pkg::NUM_W'(req_y_raw) <<< 1) - cha_pkg::NUM_W'(y_low_ff)
                 - cha_pkg::NUM_W'(y_high_ff);
   assign x_span = cha_pkg::SPAN_W'(x_high_ff) - cha_pkg::SPAN_W'(x_low_ff);
   assign y_span = cha_pkg::SPAN_W'(y_high_ff) - cha_pkg::SPAN_W'(y_low_ff);
   assign x_mag  = (x_num < 0) ? cha_pkg::NUM_W'(-x_num) : cha_pkg::NUM_W'(x_num);
   assign y_mag  = (y_num < 0) ? cha_pkg::NUM_W'(-y_num) : cha_pkg::NUM_W'(y_num);

   // s*360 as shifts and adds
   assign scaled = (cha_pkg::DIV_N_W'(wrap_ff) << 8) + (cha_pkg::DIV_N_W'(wrap_ff) << 6)
                 + (cha_pkg::DIV_N_W'(wrap_ff) << 5) + (cha_pkg::DIV_N_W'(wrap_ff) << 3);

   // X divider also serves the final degree scaling
   always_comb begin
      if (state_ff == cha_pkg::ST_SCALE) begin
         div_x_dividend = scaled;
         div_x_divisor  = cha_pkg::DIV_D_W'(cha_pkg::TOTAL);
      end else begin
         div_x_dividend = cha_pkg::DIV_N_W'({x_mag, cha_pkg::ONE_Q'(0)});
         div_x_divisor  = cha_pkg::DIV_D_W'($unsigned(x_span));
      end
   end
   assign div_y_dividend = cha_pkg::DIV_N_W'({y_mag, cha_pkg::ONE_Q'(0)});
   assign div_y_divisor  = cha_pkg::DIV_D_W'($unsigned(y_span));

   cha_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_x_start),
      .dividend (div_x_dividend),
      .divisor  (div_x_divisor),
      .done     (div_x_done),
      .quotient (div_x_quo)
   );

   cha_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_y_start),
      .dividend (div_y_dividend),
      .divisor  (div_y_divisor),
      .done     (div_y_done),
      .quotient (div_y_quo)
   );

   // saturate magnitude, restore sign, zero on a bad span
   assign x_qsat = (|div_x_quo[cha_pkg::DIV_N_W-1:cha_pkg::QSAT_W]) ? '1
                 : div_x_quo[cha_pkg::QSAT_W-1:0];
   assign y_qsat = (|div_y_quo[cha_pkg::DIV_N_W-1:cha_pkg::QSAT_W]) ? '1
                 : div_y_quo[cha_pkg::QSAT_W-1:0];
   assign x_comp = !x_ok_ff ? '0 : x_neg_ff ? -cha_pkg::COMP_W'(x_qsat)
                                            : cha_pkg::COMP_W'(x_qsat);
   assign y_comp = !y_ok_ff ? '0 : y_neg_ff ? -cha_pkg::COMP_W'(y_qsat)
                                            : cha_pkg::COMP_W'(y_qsat);

   cha_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (x_comp),
      .y_in  (y_comp),
      .rsp   (cordic_rsp)
   );

   // a full turn reads as zero degrees
   assign deg_val = (div_x_quo >= cha_pkg::DIV_N_W'(cha_pkg::DEG_TURN)) ? '0
                  : div_x_quo[cha_pkg::DEG_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cha_pkg::ST_IDLE: begin
            if (req_accept) state_in = cha_pkg::ST_NORM;
         end
         cha_pkg::ST_NORM: begin
            if (div_x_done && div_y_done) state_in = cha_pkg::ST_CORDIC;
         end
         cha_pkg::ST_CORDIC: begin
            if (cordic_rsp.done) begin
               if (count_ff == cha_pkg::CNT_W'(cha_pkg::TARGET - 1)) begin
                  state_in = cha_pkg::ST_WRAP;
               end else begin
                  state_in = cha_pkg::ST_IDLE;
               end
            end
         end
         cha_pkg::ST_WRAP:  state_in = cha_pkg::ST_SCALE;
         cha_pkg::ST_SCALE: state_in = cha_pkg::ST_FINAL;
         cha_pkg::ST_FINAL: begin
            if (div_x_done) state_in = cha_pkg::ST_OUT;
         end
         cha_pkg::ST_OUT: begin
            if (out_load) state_in = cha_pkg::ST_IDLE;
         end
         default: state_in = cha_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready    = (state_ff == cha_pkg::ST_IDLE);
      div_x_start  = req_accept || (state_ff == cha_pkg::ST_SCALE);
      div_y_start  = req_accept;
      cordic_start = (state_ff == cha_pkg::ST_NORM) && div_x_done && div_y_done;
      out_load     = (state_ff == cha_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ready);
   end

   // datapath
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      wrap_in  = wrap_ff;
      x_neg_in = x_neg_ff;
      x_ok_in  = x_ok_ff;
      y_neg_in = y_neg_ff;
      y_ok_in  = y_ok_ff;
      if (req_accept) begin
         x_neg_in = (x_num < 0);
         y_neg_in = (y_num < 0);
         x_ok_in  = (x_span > 0);
         y_ok_in  = (y_span > 0);
      end
      if (state_ff == cha_pkg::ST_CORDIC && cordic_rsp.done) begin
         sum_in   = sum_ff + cha_pkg::SUM_W'(cordic_rsp.angle) + cha_pkg::SUM_W'(decl_ff);
         count_in = count_ff + 1'b1;
      end
      if (state_ff == cha_pkg::ST_WRAP) begin
         if (sum_ff < 0) begin
            wrap_in = $unsigned(sum_ff + $signed(cha_pkg::SUM_W'(cha_pkg::TOTAL)));
         end else if (sum_ff > $signed(cha_pkg::SUM_W'(cha_pkg::TOTAL))) begin
            wrap_in = $unsigned(sum_ff - $signed(cha_pkg::SUM_W'(cha_pkg::TOTAL)));
         end else begin
            wrap_in = $unsigned(sum_ff);
         end
         sum_in   = '0;
         count_in = '0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_deg_in   = rsp_deg_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_deg_in   = deg_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cha_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         x_low_ff     <= -cha_pkg::RAW_W'(2048);
         x_high_ff    <= cha_pkg::RAW_W'(2047);
         y_low_ff     <= -cha_pkg::RAW_W'(2048);
         y_high_ff    <= cha_pkg::RAW_W'(2047);
         decl_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               cha_pkg::REG_X_LOW:  x_low_ff  <= csr_wr_data[cha_pkg::RAW_W-1:0];
               cha_pkg::REG_X_HIGH: x_high_ff <= csr_wr_data[cha_pkg::RAW_W-1:0];
               cha_pkg::REG_Y_LOW:  y_low_ff  <= csr_wr_data[cha_pkg::RAW_W-1:0];
               cha_pkg::REG_Y_HIGH: y_high_ff <= csr_wr_data[cha_pkg::RAW_W-1:0];
               cha_pkg::REG_DECL:   decl_ff   <= csr_wr_data[cha_pkg::DEC_W-1:0];
               default: ;
            endcase
         end
      end
      wrap_ff    <= wrap_in;
      x_neg_ff   <= x_neg_in;
      x_ok_ff    <= x_ok_in;
      y_neg_ff   <= y_neg_in;
      y_ok_ff    <= y_ok_in;
      rsp_deg_ff <= rsp_deg_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_heading_deg = rsp_deg_ff;

   `CHA_ASSERT_NOW(a_deg_range, clock, reset, rsp_valid, rsp_heading_deg < cha_pkg::DEG_W'(cha_pkg::DEG_TURN), "heading beyond one turn")
   `CHA_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= cha_pkg::CNT_W'(cha_pkg::TARGET), "sample count past set size")
   `CHA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "sample taken while busy")

endmodule

// ===== dv/compass_heading_checker.sv =====
// Checker for the heading averager: predicts averaged headings and compares result beats.
`timescale 1ns / 100ps

module compass_heading_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [cha_pkg::RAW_W-1:0]   req_x_raw,
   input  logic signed [cha_pkg::RAW_W-1:0]   req_y_raw,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [cha_pkg::DEG_W-1:0]          rsp_heading_deg,
   input  logic                               csr_wr_en,
   input  logic [cha_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cha_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output int                                 error_count,
   output int                                 pending_count
);

   localparam int ARCTAN [cha_pkg::ATAN_LEN] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                                 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0,
                                                 0, 0, 0};

   longint cal_x_low, cal_x_high, cal_y_low, cal_y_high, decl_offset;
   longint heading_sum;
   int     samples_in;
   logic [cha_pkg::DEG_W-1:0] expected_headings [$];

   assign pending_count = expected_headings.size();

   function automatic longint scale_axis(longint raw, longint lo, longint hi);
      longint span, n, mag, q;
      span = hi - lo;
      if (span <= 0) return 0;
      n   = 2 * (raw - lo) - span;
      mag = (n < 0) ? -n : n;
      q   = (mag * 16384) / span;
      if (q > 65535) q = 65535;
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? cha_pkg::HALF_TURN : -cha_pkg::HALF_TURN;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < cha_pkg::STEPS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += ARCTAN[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= ARCTAN[i];
         end
         x = nx;
         y = ny;
      end
      if (z < -cha_pkg::HALF_TURN) z = -cha_pkg::HALF_TURN;
      if (z > cha_pkg::HALF_TURN) z = cha_pkg::HALF_TURN;
      return z;
   endfunction

   function automatic logic [cha_pkg::DEG_W-1:0] mean_degrees(longint sum);
      longint total, deg;
      total = longint'(cha_pkg::TARGET) * cha_pkg::TURN;
      if (sum < 0) sum += total;
      if (sum > total) sum -= total;
      deg = (sum * 360) / total;
      if (deg >= 360) deg = 0;
      return cha_pkg::DEG_W'(deg);
   endfunction

   always @(posedge clock) begin
      logic [cha_pkg::DEG_W-1:0] want;
      longint xn, yn;
      if (reset) begin
         cal_x_low   = -2048;
         cal_x_high  = 2047;
         cal_y_low   = -2048;
         cal_y_high  = 2047;
         decl_offset = 0;
         heading_sum = 0;
         samples_in  = 0;
         error_count = 0;
         expected_headings.delete();
      end else begin
         // check the result beat first: it belongs to older samples
         if (rsp_valid && rsp_ready) begin
            if (expected_headings.size() == 0) begin
               $error("heading_deg: unexpected beat, actual %0d", rsp_heading_deg);
               error_count++;
            end else begin
               want = expected_headings.pop_front();
               if (rsp_heading_deg !== want) begin
                  $error("heading_deg: expected %0d, actual %0d", want, rsp_heading_deg);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            xn = scale_axis(longint'(req_x_raw), cal_x_low, cal_x_high);
            yn = scale_axis(longint'(req_y_raw), cal_y_low, cal_y_high);
            heading_sum += vector_angle(yn, xn) + decl_offset;
            samples_in++;
            if (samples_in >= cha_pkg::TARGET) begin
               expected_headings.push_back(mean_degrees(heading_sum));
               heading_sum = 0;
               samples_in  = 0;
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               cha_pkg::REG_X_LOW:
                  cal_x_low = longint'($signed(csr_wr_data[cha_pkg::RAW_W-1:0]));
               cha_pkg::REG_X_HIGH:
                  cal_x_high = longint'($signed(csr_wr_data[cha_pkg::RAW_W-1:0]));
               cha_pkg::REG_Y_LOW:
                  cal_y_low = longint'($signed(csr_wr_data[cha_pkg::RAW_W-1:0]));
               cha_pkg::REG_Y_HIGH:
                  cal_y_high = longint'($signed(csr_wr_data[cha_pkg::RAW_W-1:0]));
               cha_pkg::REG_DECL:
                  decl_offset = longint'($signed(csr_wr_data));
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== dv/tb_compass_heading_averager.sv =====
// Top of the heading averager testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_compass_heading_averager;

   localparam int STALL_LIMIT = 20000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic signed [cha_pkg::RAW_W-1:0] req_x_raw = '0;
   logic signed [cha_pkg::RAW_W-1:0] req_y_raw = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [cha_pkg::DEG_W-1:0]        rsp_heading_deg;
   logic                             csr_wr_en = 1'b0;
   logic [cha_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [cha_pkg::CSR_DATA_W-1:0]   csr_wr_data = '0;
   int                               error_count;
   int                               pending_count;
   logic                             no_idle = 1'b0;
   int                               quiet_cycles = 0;
   int                               x_lo, x_hi, y_lo, y_hi;

   compass_heading_averager dut (.*);

   compass_heading_checker checker_i (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver stalls at random about 35 percent of the time unless the quiet stretch is on
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 35);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_sample(input int x, input int y);
      req_valid <= 1'b1;
      req_x_raw <= cha_pkg::RAW_W'(x);
      req_y_raw <= cha_pkg::RAW_W'(y);
      // wait for ready ahead of an edge, then take the beat at that edge
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      // drop valid for a random gap, or hold it for the next beat
      if (!no_idle && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // let a partial set finish its divide and CORDIC
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(input cha_pkg::csr_reg_type idx, input int value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= cha_pkg::CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic set_calibration(input int xl, input int xh, input int yl, input int yh,
                                  input int decl);
      write_reg(cha_pkg::REG_X_LOW, xl);
      write_reg(cha_pkg::REG_X_HIGH, xh);
      write_reg(cha_pkg::REG_Y_LOW, yl);
      write_reg(cha_pkg::REG_Y_HIGH, yh);
      write_reg(cha_pkg::REG_DECL, decl);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      x_lo = xl; x_hi = xh; y_lo = yl; y_hi = yh;
   endtask

   function automatic int pick_raw(input int lo, input int hi);
      if (hi > lo && $urandom_range(0, 99) < 80) return lo + int'($urandom_range(0, hi - lo));
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   task automatic random_samples(input int count);
      for (int i = 0; i < count; i++) send_sample(pick_raw(x_lo, x_hi), pick_raw(y_lo, y_hi));
   endtask

   initial begin
      x_lo = -2048; x_hi = 2047; y_lo = -2048; y_hi = 2047;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and all four quadrants at reset calibration
      send_sample(-2048, -2048);
      send_sample(2047, 2047);
      send_sample(-2048, 2047);
      send_sample(2047, -2048);
      send_sample(-2048, 0);
      send_sample(-2048, -1);
      send_sample(0, 2047);
      send_sample(0, -2048);
      send_sample(2047, 0);
      send_sample(-1, 0);
      drain();

      // zero and negative spans: both components zero
      set_calibration(100, 100, 2047, -2048, -32768);
      for (int i = 0; i < 10; i++) send_sample(i * 300 - 2048, 2047 - i * 200);
      drain();

      // narrow span: raw beyond calibration saturates
      set_calibration(0, 1, -1, 0, 32767);
      send_sample(-2048, 2047);
      send_sample(2047, -2048);
      send_sample(-2048, -2048);
      send_sample(2047, 2047);
      send_sample(0, -1);
      drain();

      // random part over several calibrations, with a stretch of no idling
      for (int phase = 0; phase < 10; phase++) begin
         int a, b, c, d;
         a = int'($urandom_range(0, 4095)) - 2048;
         b = int'($urandom_range(0, 4095)) - 2048;
         c = int'($urandom_range(0, 4095)) - 2048;
         d = int'($urandom_range(0, 4095)) - 2048;
         case (phase)
            0: set_calibration(-2048, 2047, -2048, 2047, 0);
            1: set_calibration(-2048, 2047, -2048, 2047, 32767);
            2: set_calibration(-2048, 2047, -2048, 2047, -32768);
            3: set_calibration(a, b, c, d, int'($urandom_range(0, 65535)));
            default: begin
               if (phase % 3 == 0) set_calibration(a, b, c, d, int'($urandom_range(0, 65535)));
               else set_calibration((a < b) ? a : b, (a < b) ? b : a, (c < d) ? c : d,
                                    (c < d) ? d : c, int'($urandom_range(0, 65535)) - 32768);
            end
         endcase
         no_idle = (phase == 5);
         random_samples(55);
         // hold the sender until every pending heading is out
         req_valid <= 1'b0;
         @(posedge clock);
         while (pending_count != 0) @(posedge clock);
         random_samples(55);
         no_idle = 1'b0;
         drain();
      end

      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cha_pkg.sv
rtl/core/cha_div.sv
rtl/core/cha_cordic.sv
rtl/core/compass_heading_averager.sv
dv/compass_heading_checker.sv
dv/tb_compass_heading_averager.sv
